>>> design/argb_to_framebuffer_pixel_defines.svh
// Assertion macros of the pixel conversion pipeline, included by afp_merge.
`ifndef ARGB_TO_FRAMEBUFFER_PIXEL_DEFINES_SVH
`define ARGB_TO_FRAMEBUFFER_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/afp_pkg.sv
// Types and constants of the ARGB to frame buffer pixel pipeline.
`default_nettype none

package afp_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 15;

  localparam logic [CfgIndexWidth-1:0] REG_RED_FORMAT   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_GREEN_FORMAT = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_BLUE_FORMAT  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ALPHA_FORMAT = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_PIXEL_SIZE   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_SCREEN_W     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_SCREEN_H     = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_LINE_STRIDE  = 3'd7;

  localparam logic [8:0]  RST_RED_FORMAT   = 9'd139;
  localparam logic [8:0]  RST_GREEN_FORMAT = 9'd86;
  localparam logic [8:0]  RST_BLUE_FORMAT  = 9'd5;
  localparam logic [8:0]  RST_ALPHA_FORMAT = 9'd0;
  localparam logic        RST_PIXEL_SIZE   = 1'b0;
  localparam logic [12:0] RST_SCREEN_W     = 13'd320;
  localparam logic [12:0] RST_SCREEN_H     = 13'd240;
  localparam logic [14:0] RST_LINE_STRIDE  = 15'd640;

  localparam logic [3:0] CHAN_BITS = 4'd8;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  typedef struct packed {
    logic [8:0]  red_format;
    logic [8:0]  green_format;
    logic [8:0]  blue_format;
    logic [8:0]  alpha_format;
    logic        pixel_size_mode;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [14:0] line_stride_bytes;
  } cfg_t;

  typedef struct packed {
    logic        on;
    logic        half;
    logic [12:0] x;
    logic [12:0] y;
    logic [31:0] argb;
  } clip_t;

  typedef struct packed {
    logic             on;
    logic             half;
    logic [27:0]      row_offset;
    logic [14:0]      col_offset;
    logic [3:0][31:0] chan_word;
  } part_t;

  typedef struct packed {
    logic        write_enable;
    logic        half_word;
    logic [25:0] byte_offset;
    logic [31:0] pixel_word;
  } result_t;

  function automatic logic [31:0] pack_channel(input logic [7:0] chan, input logic [8:0] fmt);
    logic [3:0]  len;
    logic [7:0]  kept;
    logic [31:0] word;
    len  = (fmt[3:0] > CHAN_BITS) ? CHAN_BITS : fmt[3:0];
    kept = chan >> (CHAN_BITS - len);
    word = {24'd0, kept} << fmt[8:4];
    if (len == 4'd0) begin
      word = 32'd0;
    end
    return word;
  endfunction

endpackage

`default_nettype wire

>>> design/afp_cfg_regs.sv
// Configuration register file of the pixel pipeline.
`default_nettype none

module afp_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [afp_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [afp_pkg::CfgDataWidth-1:0]    cfg_data,
  output afp_pkg::cfg_t                            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_format        <= afp_pkg::RST_RED_FORMAT;
      cfg.green_format      <= afp_pkg::RST_GREEN_FORMAT;
      cfg.blue_format       <= afp_pkg::RST_BLUE_FORMAT;
      cfg.alpha_format      <= afp_pkg::RST_ALPHA_FORMAT;
      cfg.pixel_size_mode   <= afp_pkg::RST_PIXEL_SIZE;
      cfg.screen_width      <= afp_pkg::RST_SCREEN_W;
      cfg.screen_height     <= afp_pkg::RST_SCREEN_H;
      cfg.line_stride_bytes <= afp_pkg::RST_LINE_STRIDE;
    end else if (cfg_valid) begin
      case (cfg_index)
        afp_pkg::REG_RED_FORMAT:   cfg.red_format        <= cfg_data[8:0];
        afp_pkg::REG_GREEN_FORMAT: cfg.green_format      <= cfg_data[8:0];
        afp_pkg::REG_BLUE_FORMAT:  cfg.blue_format       <= cfg_data[8:0];
        afp_pkg::REG_ALPHA_FORMAT: cfg.alpha_format      <= cfg_data[8:0];
        afp_pkg::REG_PIXEL_SIZE:   cfg.pixel_size_mode   <= cfg_data[0];
        afp_pkg::REG_SCREEN_W:     cfg.screen_width      <= cfg_data[12:0];
        afp_pkg::REG_SCREEN_H:     cfg.screen_height     <= cfg_data[12:0];
        afp_pkg::REG_LINE_STRIDE:  cfg.line_stride_bytes <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/afp_clip.sv
// First stage: clip the coordinate against the screen and register the word.
`default_nettype none

module afp_clip #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire afp_pkg::cfg_t          cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_WIDTH-1:0] dest_x,
  input  wire logic [COORD_WIDTH-1:0] dest_y,
  input  wire logic [31:0]            argb_pixel,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output afp_pkg::clip_t              out_data
);

  logic signed [COORD_WIDTH-1:0] x_s;
  logic signed [COORD_WIDTH-1:0] y_s;
  logic signed [32:0]            x_ext;
  logic signed [32:0]            y_ext;
  logic                          x_on;
  logic                          y_on;

  assign x_s   = dest_x;
  assign y_s   = dest_y;
  assign x_ext = 33'(x_s);
  assign y_ext = 33'(y_s);
  assign x_on  = !x_ext[32] && (x_ext[31:0] < {19'd0, cfg.screen_width});
  assign y_on  = !y_ext[32] && (y_ext[31:0] < {19'd0, cfg.screen_height});

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.on   <= x_on && y_on;
      out_data.half <= !cfg.pixel_size_mode;
      out_data.x    <= x_ext[12:0];
      out_data.y    <= y_ext[12:0];
      out_data.argb <= argb_pixel;
    end
  end

endmodule

`default_nettype wire

>>> design/afp_addr_pack.sv
// Second stage: row and column offsets and per-channel placement.
`default_nettype none

module afp_addr_pack (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire afp_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire afp_pkg::clip_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output afp_pkg::part_t      out_data
);

  logic [27:0] row_offset;
  logic [14:0] col_offset;

  assign row_offset = {15'd0, in_data.y} * {13'd0, cfg.line_stride_bytes};
  assign col_offset = in_data.half ? {1'b0, in_data.x, 1'b0} : {in_data.x, 2'b00};

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.on           <= in_data.on;
      out_data.half         <= in_data.half;
      out_data.row_offset   <= row_offset;
      out_data.col_offset   <= col_offset;
      out_data.chan_word[0] <= afp_pkg::pack_channel(in_data.argb[23:16], cfg.red_format);
      out_data.chan_word[1] <= afp_pkg::pack_channel(in_data.argb[15:8], cfg.green_format);
      out_data.chan_word[2] <= afp_pkg::pack_channel(in_data.argb[7:0], cfg.blue_format);
      out_data.chan_word[3] <= afp_pkg::pack_channel(in_data.argb[31:24], cfg.alpha_format);
    end
  end

endmodule

`default_nettype wire

>>> design/afp_merge.sv
// Third stage: add the offsets, merge the channels and hold the result word.
`default_nettype none

`include "argb_to_framebuffer_pixel_defines.svh"

module afp_merge (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire afp_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire afp_pkg::part_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output afp_pkg::result_t    out_data
);

  logic [25:0] offset;
  logic [31:0] word;

  assign offset = in_data.row_offset[25:0] + {11'd0, in_data.col_offset};

  always_comb begin
    word = in_data.chan_word[0] | in_data.chan_word[1] |
           in_data.chan_word[2] | in_data.chan_word[3];
    if (in_data.half) begin
      word = word & afp_pkg::HALF_MASK;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.write_enable <= in_data.on;
      out_data.half_word    <= in_data.half;
      out_data.byte_offset  <= in_data.on ? offset : 26'd0;
      out_data.pixel_word   <= in_data.on ? word : 32'd0;
    end
  end

  `AFP_ASSERT_NOW(a_off_screen_zero, out_valid && !out_data.write_enable, (out_data.byte_offset == 26'd0) && (out_data.pixel_word == 32'd0), "off-screen word carries data")
  `AFP_ASSERT_NOW(a_half_upper_clear, out_valid && out_data.half_word, out_data.pixel_word[31:16] == 16'd0, "16-bit word has upper bits set")
  `AFP_ASSERT_NOW(a_half_follows_mode, out_valid, out_data.half_word == !cfg.pixel_size_mode, "half_word disagrees with pixel size")
  `AFP_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

`default_nettype wire

>>> design/argb_to_framebuffer_pixel.sv
// ARGB to frame buffer pixel converter: top level.
//
// Usage: feed one word per cycle on the s_ channel (dest_x, dest_y and a
// 32-bit ARGB pixel) while s_tready is high. Each word gives one result word on
// the m_ channel with write_enable, byte_offset, pixel_word and half_word. A
// pixel outside the screen gives write_enable 0 with zero offset and pixel data.
// Path: a word accepted on s_ goes through three register stages in order
// (clip, multiply and channel shift, offset add and channel merge), each
// with its own valid, and is offered on m_ from the last of them.
// Throughput: one word per cycle while m_tready is high.
// Stall: when m_tready is low the output word holds; upstream stages keep
// filling until they are all full, then s_tready drops. Nothing is lost.
// Configuration: write cfg_index/cfg_data with cfg_valid while no pixel is in
// flight; cfg_ready is always high.
// Reset: rst (synchronous) empties the pipeline and loads the register
// defaults (16-bit pixels, 320x240, stride 640 bytes).
`default_nettype none

module argb_to_framebuffer_pixel #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // dest_x, dest_y, argb_pixel (low to high), zero padded to bytes
  input  wire logic [((2*COORD_WIDTH+32+7)/8)*8-1:0] s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // byte_offset, pixel_word (low to high), zero padded
  output logic [63:0]                            m_tdata,
  // write_enable, half_word (low to high)
  output logic [1:0]                             m_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [afp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [afp_pkg::CfgDataWidth-1:0]  cfg_data
);

  afp_pkg::cfg_t    cfg;
  afp_pkg::clip_t   clip_data;
  afp_pkg::part_t   part_data;
  afp_pkg::result_t res_data;
  logic             clip_valid;
  logic             clip_ready;
  logic             part_valid;
  logic             part_ready;

  afp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afp_clip #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_clip (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .dest_x     (s_tdata[COORD_WIDTH-1:0]),
    .dest_y     (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .argb_pixel (s_tdata[2*COORD_WIDTH+31:2*COORD_WIDTH]),
    .out_valid  (clip_valid),
    .out_ready  (clip_ready),
    .out_data   (clip_data)
  );

  afp_addr_pack u_addr_pack (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (clip_valid),
    .in_ready  (clip_ready),
    .in_data   (clip_data),
    .out_valid (part_valid),
    .out_ready (part_ready),
    .out_data  (part_data)
  );

  afp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (part_valid),
    .in_ready  (part_ready),
    .in_data   (part_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_data)
  );

  assign m_tdata = {6'd0, res_data.pixel_word, res_data.byte_offset};
  assign m_tuser = {res_data.half_word, res_data.write_enable};

endmodule

`default_nettype wire

>>> test/argb_to_framebuffer_pixel_tb.sv
// Self-checking testbench for the ARGB to frame buffer pixel converter.
`timescale 1ns / 1ps

module argb_to_framebuffer_pixel_tb;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 120;
  localparam int DrainCycles = 8;

  // x lowest, matching the s_tdata layout
  typedef struct packed {
    logic [31:0] argb;
    logic [15:0] y;
    logic [15:0] x;
  } src_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // dest_x, dest_y, argb_pixel
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // byte_offset, pixel_word, zero padding
  logic [63:0] m_tdata;
  // write_enable, half_word
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [afp_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [afp_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  argb_to_framebuffer_pixel u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  afp_pkg::cfg_t    fb_cfg;
  src_word_t        source_pixels[$];
  afp_pkg::result_t expected_writes[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycle_count = 0;
  logic      in_fire = 1'b0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  logic      steady;

  assign steady = (results_seen >= 450) && (results_seen < 650);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] scale_channel(input logic [7:0] chan, input logic [8:0] fmt);
    int          len;
    logic [7:0]  kept;
    logic [63:0] wide;
    len = fmt[3:0];
    if (len > 8) begin
      len = 8;
    end
    if (len == 0) begin
      return 32'd0;
    end
    kept = chan >> (8 - len);
    wide = {56'd0, kept} << fmt[8:4];
    return wide[31:0];
  endfunction

  function automatic afp_pkg::result_t predict_fb_write(input src_word_t src);
    afp_pkg::result_t res;
    int          xi;
    int          yi;
    longint      lin;
    logic [63:0] lin_bits;
    logic [31:0] word;
    xi = $signed(src.x);
    yi = $signed(src.y);
    res = '0;
    res.half_word = ~fb_cfg.pixel_size_mode;
    if (xi >= 0 && yi >= 0 && xi < int'(fb_cfg.screen_width) &&
        yi < int'(fb_cfg.screen_height)) begin
      lin = longint'(yi) * longint'(fb_cfg.line_stride_bytes) +
            longint'(xi) * (fb_cfg.pixel_size_mode ? 64'sd4 : 64'sd2);
      lin_bits = lin;
      word = scale_channel(src.argb[23:16], fb_cfg.red_format) |
             scale_channel(src.argb[15:8], fb_cfg.green_format) |
             scale_channel(src.argb[7:0], fb_cfg.blue_format) |
             scale_channel(src.argb[31:24], fb_cfg.alpha_format);
      if (!fb_cfg.pixel_size_mode) begin
        word[31:16] = 16'd0;
      end
      res.write_enable = 1'b1;
      res.byte_offset  = lin_bits[25:0];
      res.pixel_word   = word;
    end
    return res;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // driver: advance on acceptance, idle at random
  always @(posedge clk) begin
    in_fire <= s_tvalid && s_tready;
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (source_pixels.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
        s_tdata  <= source_pixels.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && results_seen >= 250 && source_pixels.size() > 20) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  // monitor: record expectations, check results
  always @(posedge clk) begin : check_writes
    afp_pkg::result_t want;
    if (!rst && s_tvalid && s_tready) begin
      expected_writes.push_back(predict_fb_write(src_word_t'(s_tdata)));
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen = results_seen + 1;
      if (expected_writes.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        if (m_tuser[0] !== want.write_enable) begin
          $error("write_enable: expected %0d, got %0d", want.write_enable, m_tuser[0]);
          mismatches++;
        end
        if (m_tdata[25:0] !== want.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d", want.byte_offset, m_tdata[25:0]);
          mismatches++;
        end
        if (m_tdata[57:26] !== want.pixel_word) begin
          $error("pixel_word: expected %h, got %h", want.pixel_word, m_tdata[57:26]);
          mismatches++;
        end
        if (m_tuser[1] !== want.half_word) begin
          $error("half_word: expected %0d, got %0d", want.half_word, m_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_pixel(input int x, input int y, input logic [31:0] argb);
    src_word_t src;
    src.x = x[15:0];
    src.y = y[15:0];
    src.argb = argb;
    source_pixels.push_back(src);
  endtask

  task automatic drain_pipeline();
    while (source_pixels.size() != 0 || s_tvalid || expected_writes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic [afp_pkg::CfgIndexWidth-1:0] idx,
                               input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[afp_pkg::CfgDataWidth-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      afp_pkg::REG_RED_FORMAT:   fb_cfg.red_format        = value[8:0];
      afp_pkg::REG_GREEN_FORMAT: fb_cfg.green_format      = value[8:0];
      afp_pkg::REG_BLUE_FORMAT:  fb_cfg.blue_format       = value[8:0];
      afp_pkg::REG_ALPHA_FORMAT: fb_cfg.alpha_format      = value[8:0];
      afp_pkg::REG_PIXEL_SIZE:   fb_cfg.pixel_size_mode   = value[0];
      afp_pkg::REG_SCREEN_W:     fb_cfg.screen_width      = value[12:0];
      afp_pkg::REG_SCREEN_H:     fb_cfg.screen_height     = value[12:0];
      afp_pkg::REG_LINE_STRIDE:  fb_cfg.line_stride_bytes = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int pick_coord(input int span);
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return span - 2 + int'($urandom_range(0, 3));
      2: return int'($urandom_range(0, 3)) - 2;
      default: return int'($urandom_range(0, span + 7)) - 4;
    endcase
  endfunction

  task automatic random_phase(input int count);
    repeat (count) begin
      queue_pixel(pick_coord(fb_cfg.screen_width), pick_coord(fb_cfg.screen_height),
                  $urandom());
    end
    drain_pipeline();
  endtask

  function automatic int pick_dimension();
    case ($urandom_range(0, 9))
      0: return 4096;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(3, 400);
    endcase
  endfunction

  initial begin
    fb_cfg.red_format        = afp_pkg::RST_RED_FORMAT;
    fb_cfg.green_format      = afp_pkg::RST_GREEN_FORMAT;
    fb_cfg.blue_format       = afp_pkg::RST_BLUE_FORMAT;
    fb_cfg.alpha_format      = afp_pkg::RST_ALPHA_FORMAT;
    fb_cfg.pixel_size_mode   = afp_pkg::RST_PIXEL_SIZE;
    fb_cfg.screen_width      = afp_pkg::RST_SCREEN_W;
    fb_cfg.screen_height     = afp_pkg::RST_SCREEN_H;
    fb_cfg.line_stride_bytes = afp_pkg::RST_LINE_STRIDE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset format: corners, edges, extremes of coordinates and pixel
    queue_pixel(0, 0, 32'hFFFF_FFFF);
    queue_pixel(319, 239, 32'h0000_0000);
    queue_pixel(320, 0, 32'hFFFF_FFFF);
    queue_pixel(0, 240, 32'hFFFF_FFFF);
    queue_pixel(-1, 0, 32'hFFFF_FFFF);
    queue_pixel(0, -1, 32'hFFFF_FFFF);
    queue_pixel(-32768, -32768, 32'hFFFF_FFFF);
    queue_pixel(32767, 32767, 32'hFFFF_FFFF);
    queue_pixel(319, 0, 32'hA5C3_E17F);
    queue_pixel(0, 239, 32'h5A3C_1E80);
    queue_pixel(160, 120, 32'h1234_5678);
    drain_pipeline();

    // saturated lengths, zero length, offsets past bit 31, a 4096x4096 screen
    write_setting(afp_pkg::REG_RED_FORMAT, 9'h1FF);
    write_setting(afp_pkg::REG_GREEN_FORMAT, 9'h1F0);
    write_setting(afp_pkg::REG_BLUE_FORMAT, 9'h008);
    write_setting(afp_pkg::REG_ALPHA_FORMAT, 9'h188);
    write_setting(afp_pkg::REG_PIXEL_SIZE, 1);
    write_setting(afp_pkg::REG_SCREEN_W, 4096);
    write_setting(afp_pkg::REG_SCREEN_H, 4096);
    write_setting(afp_pkg::REG_LINE_STRIDE, 16384);
    queue_pixel(4095, 4095, 32'hFFFF_FFFF);
    queue_pixel(4096, 0, 32'hFFFF_FFFF);
    queue_pixel(0, 4096, 32'hFFFF_FFFF);
    queue_pixel(4095, 0, 32'h8080_8080);
    queue_pixel(0, 0, 32'h7F01_FE7F);
    drain_pipeline();

    // 16-bit mode cuts bits above 15; then an empty screen
    write_setting(afp_pkg::REG_PIXEL_SIZE, 0);
    write_setting(afp_pkg::REG_RED_FORMAT, 9'h0C8);
    queue_pixel(7, 9, 32'hFFFF_FFFF);
    queue_pixel(4095, 4095, 32'h00FF_00FF);
    drain_pipeline();
    write_setting(afp_pkg::REG_SCREEN_W, 0);
    write_setting(afp_pkg::REG_SCREEN_H, 0);
    queue_pixel(0, 0, 32'hFFFF_FFFF);
    queue_pixel(5, 5, 32'hFFFF_FFFF);
    drain_pipeline();

    write_setting(afp_pkg::REG_SCREEN_W, 320);
    write_setting(afp_pkg::REG_SCREEN_H, 240);
    write_setting(afp_pkg::REG_RED_FORMAT, afp_pkg::RST_RED_FORMAT);
    random_phase(100);

    repeat (7) begin
      write_setting(afp_pkg::REG_RED_FORMAT, $urandom_range(0, 511));
      write_setting(afp_pkg::REG_GREEN_FORMAT, $urandom_range(0, 511));
      write_setting(afp_pkg::REG_BLUE_FORMAT, $urandom_range(0, 511));
      write_setting(afp_pkg::REG_ALPHA_FORMAT, $urandom_range(0, 511));
      write_setting(afp_pkg::REG_PIXEL_SIZE, $urandom_range(0, 1));
      write_setting(afp_pkg::REG_SCREEN_W, pick_dimension());
      write_setting(afp_pkg::REG_SCREEN_H, pick_dimension());
      write_setting(afp_pkg::REG_LINE_STRIDE, ($urandom_range(0, 9) == 0) ? 16384 :
                    $urandom_range(0, 16384));
      random_phase(100);
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/afp_pkg.sv
design/afp_cfg_regs.sv
design/afp_clip.sv
design/afp_addr_pack.sv
design/afp_merge.sv
design/argb_to_framebuffer_pixel.sv
test/argb_to_framebuffer_pixel_tb.sv
